// ===== design/acalu_pkg.sv =====
package acalu_pkg;

    localparam int QUEUE_DEPTH = 2;

    // operation codes of the op field
    localparam logic [4:0] OP_ADD  = 5'd0;
    localparam logic [4:0] OP_ADC  = 5'd1;
    localparam logic [4:0] OP_SUB  = 5'd2;
    localparam logic [4:0] OP_SBB  = 5'd3;
    localparam logic [4:0] OP_ANA  = 5'd4;
    localparam logic [4:0] OP_XRA  = 5'd5;
    localparam logic [4:0] OP_ORA  = 5'd6;
    localparam logic [4:0] OP_CMP  = 5'd7;
    localparam logic [4:0] OP_RLC  = 5'd8;
    localparam logic [4:0] OP_RRC  = 5'd9;
    localparam logic [4:0] OP_RAL  = 5'd10;
    localparam logic [4:0] OP_RAR  = 5'd11;
    localparam logic [4:0] OP_DAA  = 5'd12;
    localparam logic [4:0] OP_CMA  = 5'd13;
    localparam logic [4:0] OP_STC  = 5'd14;
    localparam logic [4:0] OP_CMC  = 5'd15;
    localparam logic [4:0] OP_INR  = 5'd16;
    localparam logic [4:0] OP_DCR  = 5'd17;
    localparam logic [4:0] OP_LOAD = 5'd18;

    // decimal adjust constants
    localparam logic [7:0] DAA_LO_ADJ = 8'h06;
    localparam logic [7:0] DAA_HI_ADJ = 8'h60;
    localparam logic [3:0] BCD_MAX    = 4'h9;

    // operation class after decode
    typedef enum logic [4:0] {
        K_ADD, K_SUB, K_AND, K_XOR, K_OR, K_CMP,
        K_RLC, K_RRC, K_RAL, K_RAR, K_DAA, K_CMA,
        K_STC, K_CMC, K_INR, K_DCR, K_LOAD, K_NOP
    } op_kind_t;

    // decoded word handed from front to back
    typedef struct packed {
        op_kind_t   kind;
        logic       use_carry;
        logic [7:0] operand;
    } uop_t;

    typedef struct packed {
        logic p;
        logic s;
        logic z;
        logic ac;
        logic cy;
    } flags_t;

endpackage

// ===== design/acalu_decode.sv =====
module acalu_decode
    import acalu_pkg::*;
(
    input  logic [4:0] op,
    input  logic [7:0] operand,
    output uop_t       uop
);

    // classify the operation and fold the carry-in forms (ADC, SBB) into add and subtract
    always_comb
    begin
        uop.operand   = operand;
        uop.use_carry = 1'b0;
        unique case (op)
            OP_ADD:  uop.kind = K_ADD;
            OP_ADC:
            begin
                uop.kind      = K_ADD;
                uop.use_carry = 1'b1;
            end
            OP_SUB:  uop.kind = K_SUB;
            OP_SBB:
            begin
                uop.kind      = K_SUB;
                uop.use_carry = 1'b1;
            end
            OP_ANA:  uop.kind = K_AND;
            OP_XRA:  uop.kind = K_XOR;
            OP_ORA:  uop.kind = K_OR;
            OP_CMP:  uop.kind = K_CMP;
            OP_RLC:  uop.kind = K_RLC;
            OP_RRC:  uop.kind = K_RRC;
            OP_RAL:  uop.kind = K_RAL;
            OP_RAR:  uop.kind = K_RAR;
            OP_DAA:  uop.kind = K_DAA;
            OP_CMA:  uop.kind = K_CMA;
            OP_STC:  uop.kind = K_STC;
            OP_CMC:  uop.kind = K_CMC;
            OP_INR:  uop.kind = K_INR;
            OP_DCR:  uop.kind = K_DCR;
            OP_LOAD: uop.kind = K_LOAD;
            default: uop.kind = K_NOP;
        endcase
    end

endmodule

// ===== design/acalu_queue.sv =====
module acalu_queue
    import acalu_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  uop_t push_word,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output uop_t head_word
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    uop_t            mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full       = (count_reg == CntW'(Depth));
    assign head_valid = (count_reg != '0);
    assign head_word  = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

    // fill count stays in range
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CntW'(Depth))
        else $error("queue count out of range");

    // never pop an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");

    // never push a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full queue");

endmodule

// ===== design/acalu_exec.sv =====
module acalu_exec
    import acalu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  uop_t       head_word,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] result,
    output logic       carry_flag,
    output logic       aux_carry_flag,
    output logic       zero_flag,
    output logic       sign_flag,
    output logic       parity_flag
);

    logic [7:0] acc_reg, acc_next;
    flags_t     flags_reg, flags_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] result_reg;

    logic [7:0] a;
    logic [7:0] b;
    logic       cin;
    logic [8:0] add_sum;
    logic [4:0] add_nib;
    logic [8:0] sub_dif;
    logic [4:0] sub_nib;
    logic       daa_lo;
    logic       daa_hi;
    logic [8:0] daa_t1;
    logic [9:0] daa_t2;
    logic [7:0] res;
    logic       set_zsp;

    assign a   = acc_reg;
    assign b   = head_word.operand;
    assign cin = head_word.use_carry & flags_reg.cy;
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // shared adders
    assign add_sum = {1'b0, a} + {1'b0, b} + {8'd0, cin};
    assign add_nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
    assign sub_dif = {1'b0, a} - {1'b0, b} - {8'd0, cin};
    assign sub_nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

    // decimal adjust, low then high nibble correction
    // high step also sees a carry raised by the low step
    assign daa_lo = (a[3:0] > BCD_MAX) || flags_reg.ac;
    assign daa_t1 = daa_lo ? ({1'b0, a} + {1'b0, DAA_LO_ADJ}) : {1'b0, a};
    assign daa_hi = (daa_t1[7:4] > BCD_MAX) || flags_reg.cy || daa_t1[8];
    assign daa_t2 = daa_hi ? ({1'b0, daa_t1} + {2'b00, DAA_HI_ADJ}) : {1'b0, daa_t1};

    // operation execute
    always_comb
    begin
        acc_next   = acc_reg;
        flags_next = flags_reg;
        res        = acc_reg;
        set_zsp    = 1'b0;
        case (head_word.kind)
            K_ADD:
            begin
                res           = add_sum[7:0];
                flags_next.cy = add_sum[8];
                flags_next.ac = add_nib[4];
                set_zsp       = 1'b1;
                acc_next      = res;
            end
            K_SUB:
            begin
                res           = sub_dif[7:0];
                flags_next.cy = sub_dif[8];
                flags_next.ac = sub_nib[4];
                set_zsp       = 1'b1;
                acc_next      = res;
            end
            K_CMP:
            begin
                // flags follow the difference, output carries the accumulator
                res           = acc_reg;
                flags_next.cy = sub_dif[8];
                flags_next.ac = sub_nib[4];
                flags_next.z  = (sub_dif[7:0] == 8'd0);
                flags_next.s  = sub_dif[7];
                flags_next.p  = ~^sub_dif[7:0];
            end
            K_AND:
            begin
                res           = a & b;
                flags_next.cy = 1'b0;
                flags_next.ac = a[3] | b[3];
                set_zsp       = 1'b1;
                acc_next      = res;
            end
            K_XOR:
            begin
                res           = a ^ b;
                flags_next.cy = 1'b0;
                flags_next.ac = 1'b0;
                set_zsp       = 1'b1;
                acc_next      = res;
            end
            K_OR:
            begin
                res           = a | b;
                flags_next.cy = 1'b0;
                flags_next.ac = 1'b0;
                set_zsp       = 1'b1;
                acc_next      = res;
            end
            K_RLC:
            begin
                res           = {a[6:0], a[7]};
                flags_next.cy = a[7];
                acc_next      = res;
            end
            K_RRC:
            begin
                res           = {a[0], a[7:1]};
                flags_next.cy = a[0];
                acc_next      = res;
            end
            K_RAL:
            begin
                res           = {a[6:0], flags_reg.cy};
                flags_next.cy = a[7];
                acc_next      = res;
            end
            K_RAR:
            begin
                res           = {flags_reg.cy, a[7:1]};
                flags_next.cy = a[0];
                acc_next      = res;
            end
            K_DAA:
            begin
                res           = daa_t2[7:0];
                flags_next.ac = daa_lo && (a[3:0] > BCD_MAX);
                flags_next.cy = flags_reg.cy | daa_t1[8] | daa_t2[8] | daa_t2[9];
                set_zsp       = 1'b1;
                acc_next      = res;
            end
            K_CMA:
            begin
                res      = ~a;
                acc_next = res;
            end
            K_STC:
            begin
                flags_next.cy = 1'b1;
            end
            K_CMC:
            begin
                flags_next.cy = ~flags_reg.cy;
            end
            K_INR:
            begin
                res           = b + 8'd1;
                flags_next.ac = (b[3:0] == 4'hF);
                set_zsp       = 1'b1;
            end
            K_DCR:
            begin
                res           = b - 8'd1;
                flags_next.ac = (b[3:0] == 4'h0);
                set_zsp       = 1'b1;
            end
            K_LOAD:
            begin
                res      = b;
                acc_next = res;
            end
            default:
            begin
                res = acc_reg;
            end
        endcase
        if (set_zsp)
        begin
            flags_next.z = (res == 8'd0);
            flags_next.s = res[7];
            flags_next.p = ~^res;
        end
    end

    // output word register
    always_comb
    begin
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            flags_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                acc_reg   <= acc_next;
                flags_reg <= flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            result_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result         = result_reg;
    assign carry_flag     = flags_reg.cy;
    assign aux_carry_flag = flags_reg.ac;
    assign zero_flag      = flags_reg.z;
    assign sign_flag      = flags_reg.s;
    assign parity_flag    = flags_reg.p;

    // compare leaves the accumulator alone
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && head_word.kind == K_CMP |=> acc_reg == $past(acc_reg))
        else $error("compare changed accumulator");

    // increment and decrement keep carry and accumulator
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && (head_word.kind == K_INR || head_word.kind == K_DCR)
        |=> flags_reg.cy == $past(flags_reg.cy) && acc_reg == $past(acc_reg))
        else $error("inr/dcr touched carry or accumulator");

    // logic operations clear carry
    assert property (@(posedge clk) disable iff (!rst_n)
        pop && (head_word.kind == K_AND || head_word.kind == K_XOR || head_word.kind == K_OR)
        |=> !flags_reg.cy)
        else $error("logic op left carry set");

    // state only moves when a word is issued
    assert property (@(posedge clk) disable iff (!rst_n)
        !pop |=> acc_reg == $past(acc_reg) && flags_reg == $past(flags_reg))
        else $error("state changed without issue");

endmodule

// ===== design/i8080_accumulator_alu_unit.sv =====
// Accumulator ALU with carry, aux carry, zero, sign and even-parity flags. Each input word
// carries an operation code and an operand byte; each produces exactly one output word
// holding the new byte and all five flags. A decoder classifies the word into a small
// queue, and the execute stage drains it against the accumulator. Throughput is one word
// per clock while the output is not stalled, set by the accumulator and flag feedback
// loop in the execute stage. An accepted word passes through a queue slot and then the
// output register on its way out. The queue depth sets how many words the input side can
// absorb while the output is stalled, on top of the one word held in the output register.
module i8080_accumulator_alu_unit
    import acalu_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [4:0] op,
    input  logic [7:0] operand,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] result,
    output logic       carry_flag,
    output logic       aux_carry_flag,
    output logic       zero_flag,
    output logic       sign_flag,
    output logic       parity_flag
);

    uop_t dec_word;
    uop_t head_word;
    logic q_full;
    logic head_valid;
    logic pop;
    logic push;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // front: decode
    acalu_decode u_decode (
        .op      (op),
        .operand (operand),
        .uop     (dec_word)
    );

    // queue between decode and execute
    acalu_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_word  (dec_word),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_word  (head_word)
    );

    // back: execute and output register
    acalu_exec u_exec (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (head_valid),
        .head_word      (head_word),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result),
        .carry_flag     (carry_flag),
        .aux_carry_flag (aux_carry_flag),
        .zero_flag      (zero_flag),
        .sign_flag      (sign_flag),
        .parity_flag    (parity_flag)
    );

endmodule
